FILE: design/tpp_pkg.sv
// ----------------------------------------------------------------------------
// tpp_pkg: shared types and helpers for the trapezoid position profile
// State encoding, register indexes, direction codes and saturation helpers.
// ----------------------------------------------------------------------------
package tpp_pkg;

    localparam int unsigned MaxSamplesDefault = 16777215;
    localparam int unsigned PosWidthDefault   = 32;

    // register indexes on the configuration port
    localparam logic [1:0] CFG_ACCEL       = 2'd0;
    localparam logic [1:0] CFG_MAX_VEL     = 2'd1;
    localparam logic [1:0] CFG_SAMPLE_RATE = 2'd2;

    // move direction codes
    localparam logic [1:0] DIR_NONE = 2'd0;
    localparam logic [1:0] DIR_UP   = 2'd1;
    localparam logic [1:0] DIR_DOWN = 2'd3;

    // input kinds
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DIV,
        S_ST_BQ0,
        S_ST_BQ1,
        S_ST_T1,
        S_ST_T2,
        S_ST_TF,
        S_ST_TF2,
        S_ST_SQ0,
        S_SQ_MUL,
        S_SQ_CMP,
        S_SQ_END,
        S_ST_N0,
        S_ST_N1,
        S_TK_T,
        S_HA0,
        S_HA1,
        S_HA2,
        S_HA3,
        S_CR0,
        S_CR1,
        S_CR2,
        S_CR3,
        S_POS,
        S_EMIT
    } t_state;

    // saturate a 64-bit unsigned value to 32 bits
    function automatic logic [31:0] sat32(input logic [63:0] x);
        sat32 = (x[63:32] != 32'd0) ? 32'hFFFF_FFFF : x[31:0];
    endfunction

    // cap a 65-bit unsigned offset at 2^50
    function automatic logic [50:0] cap50(input logic [64:0] x);
        cap50 = (x > 65'h4_0000_0000_0000) ? 51'h4_0000_0000_0000 : x[50:0];
    endfunction

endpackage

FILE: design/trapezoid_position_profile.sv
// ----------------------------------------------------------------------------
// trapezoid_position_profile: LSPB point-to-point position trajectory
// Builds a trapezoidal (or triangular) velocity move in Q16.16 and emits one
// position sample per tick beat while a move runs.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel: tuser = kind (0 start a move, 1 sample tick), tdata holds
//   start_position and target_position. A start beat plans the move and
//   gives no result; each tick beat while a move runs gives one result beat
//   on the master channel carrying position, sample_index and tlast on the
//   final sample. A tick while idle is taken and dropped.
//   Configuration: write accel, max_velocity, sample_rate by index.
// Datapath:
//   One shared 32x32 multiplier and one radix-2 64-bit divider under a
//   sequencer. A start takes three divisions on a trapezoidal move, or two
//   divisions plus a bitwise square root on a triangular one. A tick takes
//   one division in the blend phases and a second division in the cruise
//   phase. The slave side is ready only while the sequencer idles.
// Reset and stall:
//   Reset restores default registers and idles the block. A result waits in
//   the output register while the receiver stalls; a new beat is still taken
//   and a finished tick holds until the output register frees.
// ----------------------------------------------------------------------------
module trapezoid_position_profile
    import tpp_pkg::*;
#(
    parameter int unsigned MAX_SAMPLES = MaxSamplesDefault,
    parameter int unsigned POS_WIDTH   = PosWidthDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] start_position, [63:32] target_position
    input  logic        s_axis_tuser,   // [0] kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // [31:0] position, [55:32] sample_index
    output logic        m_axis_tlast
);

    localparam logic [23:0] MaxN = 24'(MAX_SAMPLES);
    localparam logic signed [52:0] PosHi = (53'sd1 <<< (POS_WIDTH - 1)) - 53'sd1;
    localparam logic signed [52:0] PosLo = -PosHi - 53'sd1;

    // configuration registers
    logic [31:0] r_accel, r_vel;
    logic [15:0] r_rate;
    logic [31:0] a_e, v_e;
    logic [15:0] f_e;

    // move state
    t_state r_state, n_state, r_ret, n_ret;
    logic        r_moving, n_moving;
    logic [31:0] r_origin, n_origin, r_goal, n_goal;
    logic [1:0]  r_dir, n_dir;
    logic [31:0] r_t1, n_t1, r_t2, n_t2, r_tf, n_tf;
    logic [23:0] r_ntot, n_ntot, r_cnt, n_cnt;

    // work registers
    logic [31:0] r_d, n_d;
    logic [63:0] r_bq, n_bq;
    logic [63:0] r_q, n_q;
    logic [31:0] r_rem, n_rem, r_dvs, n_dvs;
    logic [5:0]  r_dcnt, n_dcnt;
    logic [63:0] r_prod;
    logic [31:0] mul_a, mul_b;
    logic [63:0] r_x, n_x, r_acc, n_acc;
    logic [39:0] r_t, n_t;
    logic [31:0] r_ht, n_ht, r_root, n_root;
    logic [4:0]  r_sbit, n_sbit;
    logic        r_from_goal, n_from_goal;
    logic [50:0] r_off, n_off;
    logic [31:0] r_res, n_res;

    // output register
    logic        r_ovalid, n_ovalid;
    logic [31:0] r_opos, n_opos;
    logic [23:0] r_oidx, n_oidx;
    logic        r_olast, n_olast;

    // helpers
    logic [32:0] rem_sh;
    logic        rem_ge;
    logic [31:0] trial;
    logic signed [32:0] diff;
    logic [32:0] diff_abs;
    logic [48:0] sum49;
    logic [64:0] sum65;
    logic [24:0] cnt_inc;
    logic signed [52:0] base53, off53, p53, pcl;
    logic        do_add, do_sub;

    assign a_e = (r_accel == 32'd0) ? 32'd1 : r_accel;
    assign v_e = (r_vel == 32'd0) ? 32'd1 : r_vel;
    assign f_e = (r_rate == 16'd0) ? 16'd1 : r_rate;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {r_oidx, r_opos};
    assign m_axis_tlast  = r_olast;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accel <= 32'd65536;
            r_vel   <= 32'd65536;
            r_rate  <= 16'd1000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_ACCEL:       r_accel <= i_cfg_data;
                CFG_MAX_VEL:     r_vel   <= i_cfg_data;
                CFG_SAMPLE_RATE: r_rate  <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // shared multiplier operand select
    assign trial = r_root | (32'd1 << r_sbit);
    always_comb begin
        mul_a = 32'd0;
        mul_b = 32'd0;
        unique case (r_state)
            S_ST_BQ0, S_CR0: begin mul_a = v_e;             mul_b = v_e;                end
            S_SQ_MUL:        begin mul_a = trial;           mul_b = trial;              end
            S_ST_N0:         begin mul_a = r_tf;            mul_b = {16'd0, f_e};       end
            S_HA0:           begin mul_a = a_e;             mul_b = r_ht;               end
            S_HA1:           begin mul_a = r_prod[63:32];   mul_b = r_ht;               end
            S_HA2:           begin mul_a = r_x[31:0];       mul_b = r_ht;               end
            S_CR2:           begin mul_a = v_e;             mul_b = r_t[31:0] - r_t1;   end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    // divider step, position combine and clamp
    assign rem_sh   = {r_rem, r_q[63]};
    assign rem_ge   = rem_sh >= {1'b0, r_dvs};
    assign diff     = {s_axis_tdata[63], s_axis_tdata[63:32]}
                    - {s_axis_tdata[31], s_axis_tdata[31:0]};
    assign diff_abs = diff[32] ? 33'(-diff) : 33'(diff);
    assign sum49    = {1'b0, r_q[47:0]} + {17'd0, r_t1};
    assign sum65    = {1'b0, r_acc} + {17'd0, r_prod[63:16]};
    assign cnt_inc  = {1'b0, r_cnt} + 25'd1;
    assign base53   = r_from_goal ? 53'(signed'(r_goal)) : 53'(signed'(r_origin));
    assign off53    = {2'b00, r_off};
    assign do_add   = (r_dir == DIR_UP && !r_from_goal) || (r_dir == DIR_DOWN && r_from_goal);
    assign do_sub   = (r_dir == DIR_DOWN && !r_from_goal) || (r_dir == DIR_UP && r_from_goal);
    assign p53      = do_add ? base53 + off53 : (do_sub ? base53 - off53 : base53);
    assign pcl      = (p53 > PosHi) ? PosHi : ((p53 < PosLo) ? PosLo : p53);

    // sequencer
    always_comb begin
        n_state = r_state;   n_ret = r_ret;       n_moving = r_moving;
        n_origin = r_origin; n_goal = r_goal;     n_dir = r_dir;
        n_t1 = r_t1;         n_t2 = r_t2;         n_tf = r_tf;
        n_ntot = r_ntot;     n_cnt = r_cnt;       n_d = r_d;
        n_bq = r_bq;         n_q = r_q;           n_rem = r_rem;
        n_dvs = r_dvs;       n_dcnt = r_dcnt;     n_x = r_x;
        n_acc = r_acc;       n_t = r_t;           n_ht = r_ht;
        n_root = r_root;     n_sbit = r_sbit;     n_from_goal = r_from_goal;
        n_off = r_off;       n_res = r_res;
        n_ovalid = r_ovalid; n_opos = r_opos;     n_oidx = r_oidx;
        n_olast = r_olast;

        // drain the output register
        if (r_ovalid && m_axis_tready) n_ovalid = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    if (s_axis_tuser == KIND_START) begin
                        n_moving = 1'b0;
                        n_origin = s_axis_tdata[31:0];
                        n_goal   = s_axis_tdata[63:32];
                        n_dir    = diff[32] ? DIR_DOWN : ((diff == 33'sd0) ? DIR_NONE : DIR_UP);
                        n_d      = diff_abs[31:0];
                        n_state  = S_ST_BQ0;
                    end else if (r_moving) begin
                        n_q = {24'd0, r_cnt, 16'd0}; n_dvs = {16'd0, f_e};
                        n_rem = 32'd0; n_dcnt = 6'd0; n_ret = S_TK_T; n_state = S_DIV;
                    end
                end
            end
            // one quotient bit per cycle
            S_DIV: begin
                n_rem  = rem_ge ? 32'(rem_sh - {1'b0, r_dvs}) : rem_sh[31:0];
                n_q    = {r_q[62:0], rem_ge};
                n_dcnt = r_dcnt + 6'd1;
                if (r_dcnt == 6'd63) begin
                    n_dcnt = 6'd0;
                    n_state = r_ret;
                end
            end
            S_ST_BQ0: n_state = S_ST_BQ1;
            S_ST_BQ1: begin
                n_q = r_prod; n_dvs = a_e; n_rem = 32'd0; n_ret = S_ST_T1; n_state = S_DIV;
            end
            S_ST_T1: begin
                n_bq = r_q; n_rem = 32'd0; n_dvs = a_e; n_state = S_DIV;
                if ({32'd0, r_d} > r_q) begin
                    n_q = {16'd0, v_e, 16'd0}; n_ret = S_ST_T2;
                end else begin
                    n_q = {16'd0, r_d, 16'd0}; n_ret = S_ST_SQ0;
                end
            end
            S_ST_T2: begin
                n_t1 = sat32(r_q);
                n_q = {16'd0, r_d - r_bq[31:0], 16'd0}; n_dvs = v_e; n_rem = 32'd0;
                n_ret = S_ST_TF; n_state = S_DIV;
            end
            S_ST_TF: begin
                n_t2 = sat32({15'd0, sum49});
                n_state = S_ST_TF2;
            end
            S_ST_TF2: begin
                n_tf = sat32({31'd0, {1'b0, r_t2} + {1'b0, r_t1}});
                n_state = S_ST_N0;
            end
            // triangular move: bitwise square root by trial squares
            S_ST_SQ0: begin
                n_x = {r_q[47:0], 16'd0}; n_root = 32'd0; n_sbit = 5'd31; n_state = S_SQ_MUL;
            end
            S_SQ_MUL: n_state = S_SQ_CMP;
            S_SQ_CMP: begin
                if (r_prod <= r_x) n_root = trial;
                if (r_sbit == 5'd0) n_state = S_SQ_END;
                else begin
                    n_sbit = r_sbit - 5'd1;
                    n_state = S_SQ_MUL;
                end
            end
            S_SQ_END: begin
                n_t1 = r_root; n_t2 = r_root;
                n_tf = sat32({31'd0, r_root, 1'b0});
                n_state = S_ST_N0;
            end
            S_ST_N0: n_state = S_ST_N1;
            S_ST_N1: begin
                n_ntot = (r_prod[63:16] > {24'd0, MaxN}) ? MaxN : r_prod[39:16];
                n_cnt = 24'd0;
                n_moving = (r_prod[63:16] != 48'd0);
                n_state = S_IDLE;
            end
            // tick: pick the phase from t
            S_TK_T: begin
                n_t = r_q[39:0];
                if (r_q[39:0] < {8'd0, r_t1}) begin
                    n_ht = r_q[31:0]; n_from_goal = 1'b0; n_state = S_HA0;
                end else if (r_q[39:0] < {8'd0, r_t2}) begin
                    n_from_goal = 1'b0; n_state = S_CR0;
                end else begin
                    n_ht = (r_q[39:0] < {8'd0, r_tf}) ? 32'(r_tf - r_q[31:0]) : 32'd0;
                    n_from_goal = 1'b1; n_state = S_HA0;
                end
            end
            S_HA0: n_state = S_HA1;
            S_HA1: begin n_x = r_prod;   n_state = S_HA2; end
            S_HA2: begin n_acc = r_prod; n_state = S_HA3; end
            S_HA3: begin
                n_off = cap50(({1'b0, r_acc} + {33'd0, r_prod[63:32]}) >> 1);
                n_state = S_POS;
            end
            S_CR0: n_state = S_CR1;
            S_CR1: begin
                n_q = r_prod; n_dvs = a_e; n_rem = 32'd0; n_ret = S_CR2; n_state = S_DIV;
            end
            S_CR2: begin n_acc = {1'b0, r_q[63:1]}; n_state = S_CR3; end
            S_CR3: begin n_off = cap50(sum65); n_state = S_POS; end
            S_POS: begin n_res = pcl[31:0]; n_state = S_EMIT; end
            // hold until the output register frees
            S_EMIT: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_ovalid = 1'b1;
                    n_opos = r_res;
                    n_oidx = r_cnt;
                    n_olast = cnt_inc >= {1'b0, r_ntot};
                    n_cnt = cnt_inc[23:0];
                    n_moving = cnt_inc < {1'b0, r_ntot};
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_ret <= S_IDLE; r_moving <= 1'b0;
            r_origin <= 32'd0; r_goal <= 32'd0; r_dir <= DIR_NONE;
            r_t1 <= 32'd0; r_t2 <= 32'd0; r_tf <= 32'd0;
            r_ntot <= 24'd0; r_cnt <= 24'd0; r_dcnt <= 6'd0; r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state; r_ret <= n_ret; r_moving <= n_moving;
            r_origin <= n_origin; r_goal <= n_goal; r_dir <= n_dir;
            r_t1 <= n_t1; r_t2 <= n_t2; r_tf <= n_tf;
            r_ntot <= n_ntot; r_cnt <= n_cnt; r_dcnt <= n_dcnt; r_ovalid <= n_ovalid;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_d <= n_d;     r_bq <= n_bq;     r_q <= n_q;     r_rem <= n_rem;
        r_dvs <= n_dvs; r_x <= n_x;       r_acc <= n_acc; r_t <= n_t;
        r_ht <= n_ht;   r_root <= n_root; r_sbit <= n_sbit;
        r_from_goal <= n_from_goal;       r_off <= n_off; r_res <= n_res;
        r_opos <= n_opos; r_oidx <= n_oidx; r_olast <= n_olast;
    end

    // checks
    a_moving_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_moving |-> (r_cnt < r_ntot))
        else $error("sample index past move length while moving");

    a_total_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ntot <= MaxN)
        else $error("sample total above cap");

    a_div_return: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_dcnt == 6'd63) |=> (r_state == $past(r_ret)))
        else $error("divider did not return to caller");

    a_last_ends_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && n_ovalid && !r_ovalid && n_olast) |=> !r_moving)
        else $error("move still running after final sample");

endmodule

FILE: verif/trapezoid_position_profile_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trapezoid_position_profile_tb: self-checking bench for the LSPB profile
// Streams start and tick beats into the block, plans each move and computes
// every position sample in Q16.16, and checks each result beat in order
// under random gaps, receiver stalls and one long output hold-off.
// ----------------------------------------------------------------------------
module trapezoid_position_profile_tb;
    import tpp_pkg::*;

    localparam logic [63:0] M32      = 64'hFFFF_FFFF;
    localparam logic [63:0] OFF_CAP  = 64'h4_0000_0000_0000;
    localparam logic [63:0] N_MAX    = 64'd16777215;
    localparam int          SETTLE   = 400;

    typedef struct {
        logic        kind;
        logic [31:0] start_pos;
        logic [31:0] target_pos;
    } t_move_beat;

    typedef struct {
        logic [31:0] position;
        logic [23:0] index;
        logic        last;
    } t_sample;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_addr;
    logic [31:0] i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;   // [31:0] start_position, [63:32] target_position
    logic        s_axis_tuser;   // [0] kind
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;   // [31:0] position, [55:32] sample_index
    logic        m_axis_tlast;

    trapezoid_position_profile dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_addr(i_cfg_addr), .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
    );

    // profile registers and move state as the block should hold them
    logic [63:0] accel_q, vel_q, rate_q;
    logic        moving;
    longint      origin_pos, goal_pos;
    logic [1:0]  move_dir;
    logic [63:0] t_blend, t_cruise, t_total, n_total, n_next;

    t_move_beat  pending_beats[$];
    t_sample     expected_samples[$];
    t_move_beat  cur_beat;
    bit          beat_taken;
    bit          gapless;
    bit          hold_go;
    int          gap_left;
    int          hold_left;
    int          mismatches;

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    function automatic logic [63:0] nz(input logic [63:0] x);
        return (x == 64'd0) ? 64'd1 : x;
    endfunction

    function automatic logic [63:0] sat32(input logic [63:0] x);
        return (x > M32) ? M32 : x;
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] n);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // a * t^2 / 2 in Q16.16, capped at 2^50
    function automatic logic [63:0] blend_offset(input logic [63:0] a, input logic [63:0] t);
        logic [63:0] x, h1, c, hi, off;
        x  = a * t;
        h1 = (x >> 32) * t;
        c  = ((x & M32) * t) >> 32;
        hi = h1 + c;
        if (hi < h1) hi = '1;
        off = hi >> 1;
        return (off > OFF_CAP) ? OFF_CAP : off;
    endfunction

    // plan blend, cruise and end times plus the sample count
    task automatic plan_move(input logic [31:0] sp, input logic [31:0] tp);
        logic [63:0] a, v, f, d, bq, t1, t2, tf, n;
        longint      x0, xf;
        a  = nz(accel_q);
        v  = nz(vel_q);
        f  = nz(rate_q);
        x0 = longint'(signed'(sp));
        xf = longint'(signed'(tp));
        origin_pos = x0;
        goal_pos   = xf;
        move_dir   = (xf > x0) ? DIR_UP : ((xf < x0) ? DIR_DOWN : DIR_NONE);
        d  = (xf > x0) ? 64'(xf - x0) : 64'(x0 - xf);
        bq = (v * v) / a;
        if (d > bq) begin
            t1 = sat32((v << 16) / a);
            t2 = sat32(t1 + (((d - bq) << 16) / v));
            tf = sat32(t2 + t1);
        end else begin
            t1 = sat32(int_sqrt(((d << 16) / a) << 16));
            t2 = t1;
            tf = sat32(2 * t1);
        end
        t_blend  = t1;
        t_cruise = t2;
        t_total  = tf;
        n = (tf * f) >> 16;
        if (n > N_MAX) n = N_MAX;
        n_total = n;
        n_next  = 0;
        moving  = (n != 0);
    endtask

    // apply one accepted beat to the move state, queue any sample it yields
    task automatic advance_profile(input t_move_beat b);
        logic [63:0] a, v, f, i, t, off, dt;
        longint      sgn, p;
        t_sample     s;
        if (b.kind == KIND_START) begin
            plan_move(b.start_pos, b.target_pos);
            return;
        end
        if (!moving) return;
        a = nz(accel_q);
        v = nz(vel_q);
        f = nz(rate_q);
        i = n_next;
        t = (i << 16) / f;
        sgn = (move_dir == DIR_UP) ? 1 : ((move_dir == DIR_DOWN) ? -1 : 0);
        if (t < t_blend) begin
            p = origin_pos + sgn * longint'(blend_offset(a, t));
        end else if (t < t_cruise) begin
            off = (((v * v) / a) >> 1) + ((v * (t - t_blend)) >> 16);
            if (off > OFF_CAP) off = OFF_CAP;
            p = origin_pos + sgn * longint'(off);
        end else begin
            dt = (t < t_total) ? t_total - t : 64'd0;
            p = goal_pos - sgn * longint'(blend_offset(a, dt));
        end
        if (p > 64'sd2147483647) p = 64'sd2147483647;
        if (p < -64'sd2147483648) p = -64'sd2147483648;
        s.position = p[31:0];
        s.index    = i[23:0];
        s.last     = (i + 1 >= n_total);
        expected_samples.push_back(s);
        n_next = i + 1;
        if (n_next >= n_total) moving = 0;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (gapless || r < 13) return 0;
        if (r < 18) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // accept input beats and output beats at the rising edge
    always @(posedge i_clk) begin
        t_sample exp_s;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            advance_profile(cur_beat);
            beat_taken = 1;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_samples.size() == 0) begin
                $display("%0t: unexpected sample pos=%h idx=%0d last=%b", $time,
                         m_axis_tdata[31:0], m_axis_tdata[55:32], m_axis_tlast);
                mismatches++;
            end else begin
                exp_s = expected_samples.pop_front();
                if (m_axis_tdata[31:0] !== exp_s.position ||
                    m_axis_tdata[55:32] !== exp_s.index ||
                    m_axis_tlast !== exp_s.last) begin
                    $display("%0t: sample mismatch expected pos=%h idx=%0d last=%b",
                             $time, exp_s.position, exp_s.index, exp_s.last);
                    $display("%0t:                 actual   pos=%h idx=%0d last=%b",
                             $time, m_axis_tdata[31:0], m_axis_tdata[55:32], m_axis_tlast);
                    mismatches++;
                end
            end
        end
    end

    // drive input beats at the falling edge
    always @(negedge i_clk) begin
        if (i_rst_n && (beat_taken || !s_axis_tvalid)) begin
            beat_taken = 0;
            if (gap_left > 0) begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end else if (pending_beats.size() != 0) begin
                cur_beat = pending_beats.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= cur_beat.kind;
                s_axis_tdata  <= {cur_beat.target_pos, cur_beat.start_pos};
                gap_left = pick_gap();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver stalls, with one long hold-off on request
    always @(negedge i_clk) begin
        if (hold_go) begin
            hold_go = 0;
            hold_left = 3000;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= gapless ? 1'b1 : ($urandom_range(0, 9) < 7);
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_ACCEL:       accel_q = {32'd0, val};
            CFG_MAX_VEL:     vel_q   = {32'd0, val};
            CFG_SAMPLE_RATE: rate_q  = {48'd0, val[15:0]};
            default: ;
        endcase
    endtask

    task automatic add_beat(input logic kind, input logic [31:0] sp, input logic [31:0] tp);
        t_move_beat b;
        b.kind = kind;
        b.start_pos = sp;
        b.target_pos = tp;
        pending_beats.push_back(b);
    endtask

    task automatic add_ticks(input int n);
        repeat (n) add_beat(KIND_TICK, $urandom, $urandom);
    endtask

    // wait for all beats to go in and all samples to come out, then settle
    task automatic drain();
        while (pending_beats.size() != 0 || s_axis_tvalid || expected_samples.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // well-formed moves with random content, plus some noise
    task automatic random_phase(input int n_beats);
        int          made;
        logic [31:0] sp, step;
        made = 0;
        while (made < n_beats) begin
            if ($urandom_range(0, 99) < 85) begin
                sp = $urandom;
                step = $urandom_range(0, 3) == 0 ? $urandom : ($urandom >> $urandom_range(8, 30));
                add_beat(KIND_START, sp, $urandom_range(0, 1) ? sp + step : sp - step);
                made += 1 + $urandom_range(1, 15);
                add_ticks(made > n_beats ? 1 : $urandom_range(1, 15));
            end else begin
                add_beat($urandom_range(0, 1), $urandom, $urandom);
                made++;
            end
        end
        drain();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_addr = '0;
        i_cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = KIND_TICK;
        m_axis_tready = 1'b0;
        beat_taken = 0;
        gapless = 0;
        hold_go = 0;
        gap_left = 0;
        hold_left = 0;
        mismatches = 0;
        accel_q = 64'd65536;
        vel_q = 64'd65536;
        rate_q = 64'd1000;
        moving = 0;
        origin_pos = 0;
        goal_pos = 0;
        move_dir = DIR_NONE;
        t_blend = 0;
        t_cruise = 0;
        t_total = 0;
        n_total = 0;
        n_next = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: triangular move, trapezoid downward, restart, empty move, idle tick
        write_reg(CFG_SAMPLE_RATE, 32'd4);
        add_beat(KIND_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_beat(KIND_START, 32'd0, 32'h0001_0000);
        add_ticks(9);
        add_beat(KIND_START, 32'h0002_0000, 32'hFFFD_0000);
        add_ticks(5);
        add_beat(KIND_START, 32'h7FFF_FFFF, 32'h8000_0000);
        add_ticks(3);
        add_beat(KIND_START, 32'h8000_0000, 32'h8000_0000);
        add_beat(KIND_TICK, 32'd0, 32'd0);
        add_beat(KIND_START, 32'h8000_0000, 32'h7FFF_FFFF);
        add_ticks(2);
        drain();

        // register extremes
        write_reg(CFG_ACCEL, 32'hFFFF_FFFF);
        write_reg(CFG_MAX_VEL, 32'd1);
        write_reg(CFG_SAMPLE_RATE, 32'd65535);
        random_phase(70);

        write_reg(CFG_ACCEL, 32'd1);
        write_reg(CFG_MAX_VEL, 32'hFFFF_FFFF);
        write_reg(CFG_SAMPLE_RATE, 32'd1);
        random_phase(60);

        // long output hold-off while ticks keep coming
        write_reg(CFG_ACCEL, 32'h0004_0000);
        write_reg(CFG_MAX_VEL, 32'h0002_0000);
        write_reg(CFG_SAMPLE_RATE, 32'd50);
        hold_go = 1;
        add_beat(KIND_START, 32'hFFF0_0000, 32'h0010_0000);
        add_ticks(20);
        drain();

        gapless = 1;
        random_phase(60);
        gapless = 0;

        repeat (6) begin
            write_reg(CFG_ACCEL, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1, 32'h0100_0000));
            write_reg(CFG_MAX_VEL, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1, 32'h0100_0000));
            write_reg(CFG_SAMPLE_RATE, $urandom_range(0, 3) == 0 ? $urandom_range(1, 65535)
                                                              : $urandom_range(1, 300));
            random_phase(70);
        end

        if (mismatches == 0 && expected_samples.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("Some tests failed");
        $finish;
    end

endmodule

FILE: trapezoid_position_profile.f
design/tpp_pkg.sv
design/trapezoid_position_profile.sv
verif/trapezoid_position_profile_tb.sv
